/* rtl/core/afwc_pkg.sv */
// ----------------------------------------------------------------------------
// afwc_pkg: shared types and constants of the allele frequency window counter
// Field widths, arithmetic widths of the window test and the word types that
// travel between the front pipeline, the queue and the counter back end.
// ----------------------------------------------------------------------------
package afwc_pkg;

    // Sizing of the block.
    localparam int COUNT_BITS    = 40;
    localparam int COVERAGE_BITS = 16;
    localparam int NUM_WINDOWS   = 8;

    // Fixed field widths.
    localparam int PLOIDY_W     = 4;
    localparam int WIDTH_W      = 8;
    localparam int WINDOW_SLOTS = 8;
    localparam int OUT_COUNT_W  = 40;
    localparam int CFG_INDEX_W  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_E = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_F = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_G = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_H = 3'd7;

    // Half-widths after reset, in tenths, window a in the low byte.
    localparam logic [WINDOW_SLOTS-1:0][WIDTH_W-1:0] RESET_WIDTHS =
        {8'd60, 8'd50, 8'd40, 8'd30, 8'd20, 8'd10, 8'd3, 8'd1};

    // Arithmetic widths of the test 100*(m*k - c)^2 < L^2*(k-1)*c.
    localparam int MK_W      = COVERAGE_BITS + PLOIDY_W;
    localparam int DSQ_W     = 2 * MK_W;
    localparam int LHS_SCALE = 100;
    localparam int LHS_W     = DSQ_W + 7;
    localparam int LSQ_W     = 2 * WIDTH_W;
    localparam int RHS_W     = LSQ_W + MK_W;
    localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // Width used to move a counter into an output field of fixed width.
    localparam int WIDE_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
    localparam logic [WIDE_W-1:0] COUNT_MAX_WIDE = WIDE_W'({COUNT_BITS{1'b1}});
    localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_SAT = COUNT_MAX_WIDE[OUT_COUNT_W-1:0];

    typedef logic [WINDOW_SLOTS-1:0][LSQ_W-1:0] lsq_array_t;

    typedef struct packed {
        logic [COVERAGE_BITS-1:0] coverage;
        logic [COVERAGE_BITS-1:0] mutated_reads;
        logic [PLOIDY_W-1:0]      ploidy;
    } in_word_t;

    typedef struct packed {
        logic [WINDOW_SLOTS-1:0] pass_mask;
        logic [OUT_COUNT_W-1:0]  count_a;
        logic [OUT_COUNT_W-1:0]  count_b;
        logic [OUT_COUNT_W-1:0]  count_c;
        logic [OUT_COUNT_W-1:0]  count_d;
        logic [OUT_COUNT_W-1:0]  count_e;
        logic [OUT_COUNT_W-1:0]  count_f;
        logic [OUT_COUNT_W-1:0]  count_g;
        logic [OUT_COUNT_W-1:0]  count_h;
        logic [OUT_COUNT_W-1:0]  records_seen;
    } out_word_t;

    // What the front hands to the back for one record.
    typedef struct packed {
        logic [WINDOW_SLOTS-1:0] mask;
    } mask_word_t;

    // Low bits of a counter, zero extended when the counter is narrower.
    function automatic logic [OUT_COUNT_W-1:0] count_to_out(input logic [COUNT_BITS-1:0] v);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(v);
        return wide[OUT_COUNT_W-1:0];
    endfunction

endpackage

/* rtl/core/afwc_front.sv */
// ----------------------------------------------------------------------------
// afwc_front: window test pipeline
// Three register stages turn one record into its pass mask: products, then
// the squared distance and the eight window bounds, then the comparisons.
// ----------------------------------------------------------------------------
module afwc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  afwc_pkg::in_word_t     in_word,
    input  afwc_pkg::lsq_array_t   lsq,
    output logic                   out_valid,
    output afwc_pkg::mask_word_t   out_word,
    input  logic                   out_stall
);
    import afwc_pkg::*;

    typedef logic [WINDOW_SLOTS-1:0][RHS_W-1:0] rhs_array_t;

    logic                     s1_valid_reg;
    logic [MK_W-1:0]          s1_mk_reg;
    logic [MK_W-1:0]          s1_ck_reg;
    logic [COVERAGE_BITS-1:0] s1_cov_reg;
    logic                     s1_skip_reg;

    logic                     s2_valid_reg;
    logic [DSQ_W-1:0]         s2_dsq_reg;
    rhs_array_t               s2_rhs_reg;
    logic                     s2_skip_reg;

    logic                     s3_valid_reg;
    logic [WINDOW_SLOTS-1:0]  s3_mask_reg;

    logic                     s1_ready, s2_ready, s3_ready, in_take;
    logic [MK_W-1:0]          in_mk, in_ck;
    logic [PLOIDY_W-1:0]      in_km1;
    logic                     in_skip;
    logic [MK_W-1:0]          cov_ext, diff;
    logic [DSQ_W-1:0]         dsq;
    rhs_array_t               rhs;
    logic [CMP_W-1:0]         lhs;
    logic [WINDOW_SLOTS-1:0]  hit;

    // A stage moves on when it is empty or its successor moves on.
    assign s3_ready = !s3_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign in_take  = in_valid && s1_ready;

    always_comb
    begin
        in_km1  = in_word.ploidy - PLOIDY_W'(1);
        in_mk   = MK_W'(in_word.mutated_reads) * MK_W'(in_word.ploidy);
        in_ck   = MK_W'(in_word.coverage) * MK_W'(in_km1);
        // Ploidy zero or one never passes.
        in_skip = (in_word.ploidy <= PLOIDY_W'(1));
    end

    always_comb
    begin
        cov_ext = MK_W'(s1_cov_reg);
        diff    = (s1_mk_reg >= cov_ext) ? (s1_mk_reg - cov_ext) : (cov_ext - s1_mk_reg);
        dsq     = DSQ_W'(diff) * DSQ_W'(diff);
        for (int i = 0; i < WINDOW_SLOTS; i++)
        begin
            rhs[i] = RHS_W'(lsq[i]) * RHS_W'(s1_ck_reg);
        end
    end

    // Zero coverage or zero half-width gives a zero bound, so no pass.
    always_comb
    begin
        lhs = CMP_W'(s2_dsq_reg) * CMP_W'(LHS_SCALE);
        for (int i = 0; i < WINDOW_SLOTS; i++)
        begin
            hit[i] = (i < NUM_WINDOWS) && !s2_skip_reg && (lhs < CMP_W'(s2_rhs_reg[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_take;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mk_reg   <= in_mk;
            s1_ck_reg   <= in_ck;
            s1_cov_reg  <= in_word.coverage;
            s1_skip_reg <= in_skip;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_dsq_reg  <= dsq;
            s2_rhs_reg  <= rhs;
            s2_skip_reg <= s1_skip_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_mask_reg <= hit;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign out_word.mask = s3_mask_reg;

endmodule

/* rtl/core/afwc_queue.sv */
// ----------------------------------------------------------------------------
// afwc_queue: four-entry mask queue
// Decouples the window test pipeline from the counter back end.
// ----------------------------------------------------------------------------
module afwc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_stall,
    input  afwc_pkg::mask_word_t push_word,
    output logic                 pop_valid,
    output afwc_pkg::mask_word_t pop_word,
    input  logic                 pop_stall
);
    import afwc_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    mask_word_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   fill_reg, fill_next;
    logic                push, pop;

    assign push_stall = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_word   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* rtl/core/afwc_back.sv */
// ----------------------------------------------------------------------------
// afwc_back: saturating counters and result register
// Takes one mask per cycle unless a held result stalls it, updates the pass
// and record counters and holds the finished result word until it is taken.
// ----------------------------------------------------------------------------
module afwc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mask_valid,
    output logic                 mask_stall,
    input  afwc_pkg::mask_word_t mask_word,
    output logic                 out_valid,
    output afwc_pkg::out_word_t  out_word,
    input  logic                 out_stall
);
    import afwc_pkg::*;

    typedef logic [WINDOW_SLOTS-1:0][COUNT_BITS-1:0] count_array_t;
    typedef logic [WINDOW_SLOTS-1:0][OUT_COUNT_W-1:0] out_count_array_t;

    count_array_t            pass_cnt_reg, pass_cnt_next;
    logic [COUNT_BITS-1:0]   rec_cnt_reg, rec_cnt_next;
    logic                    out_valid_reg;
    out_word_t               out_word_reg, out_word_next;
    out_count_array_t        shown;
    logic                    take;

    assign mask_stall = out_valid_reg && out_stall;
    assign take       = mask_valid && !mask_stall;

    always_comb
    begin
        for (int i = 0; i < WINDOW_SLOTS; i++)
        begin
            if (mask_word.mask[i] && (pass_cnt_reg[i] != '1))
            begin
                pass_cnt_next[i] = pass_cnt_reg[i] + COUNT_BITS'(1);
            end
            else
            begin
                pass_cnt_next[i] = pass_cnt_reg[i];
            end
            shown[i] = (i < NUM_WINDOWS) ? count_to_out(pass_cnt_next[i]) : '0;
        end
        rec_cnt_next = (rec_cnt_reg != '1) ? rec_cnt_reg + COUNT_BITS'(1) : rec_cnt_reg;

        out_word_next.pass_mask    = mask_word.mask;
        out_word_next.count_a      = shown[0];
        out_word_next.count_b      = shown[1];
        out_word_next.count_c      = shown[2];
        out_word_next.count_d      = shown[3];
        out_word_next.count_e      = shown[4];
        out_word_next.count_f      = shown[5];
        out_word_next.count_g      = shown[6];
        out_word_next.count_h      = shown[7];
        out_word_next.records_seen = count_to_out(rec_cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_cnt_reg  <= '0;
            rec_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pass_cnt_reg <= pass_cnt_next;
                rec_cnt_reg  <= rec_cnt_next;
            end
            if (!mask_stall)
            begin
                out_valid_reg <= mask_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* rtl/core/allele_frequency_window_counter.sv */
// ----------------------------------------------------------------------------
// allele_frequency_window_counter: allele frequency window counter
// Tests each read record against eight frequency windows around 1/ploidy
// and keeps saturating pass counts per window and a record count.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Word
//   -------   ---------  -------------------  ---------------------------------
//   in        input      in_valid / in_stall   coverage, mutated_reads, ploidy
//   out       output     out_valid / out_stall pass mask, eight counts, records
//   cfg       input      cfg_write             cfg_index, cfg_data (8 bits)
//
// One word is accepted per clock cycle for as long as the output side keeps
// up. A result word passes through the three register stages of the window
// test (the first loads on the accepting edge), one queue slot and the output
// register before it is presented.
// A four-entry queue sits between the test pipeline and the counters, so an
// output stall fills the queue before the input stalls.
// Reset clears all counters and loads the default half-widths.
//
module allele_frequency_window_counter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  afwc_pkg::in_word_t                    in_word,
    output logic                                  out_valid,
    output afwc_pkg::out_word_t                   out_word,
    input  logic                                  out_stall,
    input  logic                                  cfg_write,
    input  logic [afwc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [afwc_pkg::WIDTH_W-1:0]          cfg_data
);
    import afwc_pkg::*;

    // The test only ever needs the square of each half-width, so the square
    // is formed on the write and kept in place of the written value.
    lsq_array_t              lsq_reg, lsq_next;

    logic                    fq_valid, fq_stall;
    mask_word_t              fq_word;
    logic                    qb_valid, qb_stall;
    mask_word_t              qb_word;

    always_comb
    begin
        lsq_next = lsq_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH_A: lsq_next[0] = LSQ_W'(cfg_data) * LSQ_W'(cfg_data);
                REG_WIDTH_B: lsq_next[1] = LSQ_W'(cfg_data) * LSQ_W'(cfg_data);
                REG_WIDTH_C: lsq_next[2] = LSQ_W'(cfg_data) * LSQ_W'(cfg_data);
                REG_WIDTH_D: lsq_next[3] = LSQ_W'(cfg_data) * LSQ_W'(cfg_data);
                REG_WIDTH_E: lsq_next[4] = LSQ_W'(cfg_data) * LSQ_W'(cfg_data);
                REG_WIDTH_F: lsq_next[5] = LSQ_W'(cfg_data) * LSQ_W'(cfg_data);
                REG_WIDTH_G: lsq_next[6] = LSQ_W'(cfg_data) * LSQ_W'(cfg_data);
                REG_WIDTH_H: lsq_next[7] = LSQ_W'(cfg_data) * LSQ_W'(cfg_data);
                default:     lsq_next    = lsq_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_SLOTS; i++)
            begin
                lsq_reg[i] <= LSQ_W'(RESET_WIDTHS[i]) * LSQ_W'(RESET_WIDTHS[i]);
            end
        end
        else
        begin
            lsq_reg <= lsq_next;
        end
    end

    // Front: products, squared distance, bounds and the comparisons.
    afwc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .lsq       (lsq_reg),
        .out_valid (fq_valid),
        .out_word  (fq_word),
        .out_stall (fq_stall)
    );

    // Queue: lets the front keep working while a result waits at the output.
    afwc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_stall (fq_stall),
        .push_word  (fq_word),
        .pop_valid  (qb_valid),
        .pop_word   (qb_word),
        .pop_stall  (qb_stall)
    );

    // Back: counters and the output register.
    afwc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mask_valid (qb_valid),
        .mask_stall (qb_stall),
        .mask_word  (qb_word),
        .out_valid  (out_valid),
        .out_word   (out_word),
        .out_stall  (out_stall)
    );

    // Checks on the counters as seen in the result words.
    logic [WINDOW_SLOTS-1:0] count_nonzero;
    logic [WINDOW_SLOTS-1:0] count_le_records;

    always_comb
    begin
        count_nonzero[0]    = (out_word.count_a != '0);
        count_nonzero[1]    = (out_word.count_b != '0);
        count_nonzero[2]    = (out_word.count_c != '0);
        count_nonzero[3]    = (out_word.count_d != '0);
        count_nonzero[4]    = (out_word.count_e != '0);
        count_nonzero[5]    = (out_word.count_f != '0);
        count_nonzero[6]    = (out_word.count_g != '0);
        count_nonzero[7]    = (out_word.count_h != '0);
        count_le_records[0] = (out_word.count_a <= out_word.records_seen);
        count_le_records[1] = (out_word.count_b <= out_word.records_seen);
        count_le_records[2] = (out_word.count_c <= out_word.records_seen);
        count_le_records[3] = (out_word.count_d <= out_word.records_seen);
        count_le_records[4] = (out_word.count_e <= out_word.records_seen);
        count_le_records[5] = (out_word.count_f <= out_word.records_seen);
        count_le_records[6] = (out_word.count_g <= out_word.records_seen);
        count_le_records[7] = (out_word.count_h <= out_word.records_seen);
    end

    // Each result word follows the previous one by exactly one record.
    a_records_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && (out_word.records_seen != OUT_COUNT_SAT)) |=>
        (!out_valid ||
         (out_word.records_seen == OUT_COUNT_W'($past(out_word.records_seen) + 1'b1))))
        else $error("records_seen did not advance by one between results");

    // A window that passed this record has a nonzero count.
    a_pass_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_word.pass_mask & ~count_nonzero) == '0))
        else $error("pass mask bit set with a zero pass count");

    // No window can have passed more records than were seen.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_le_records == '1))
        else $error("pass count exceeds records_seen");

endmodule
